// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: payload types, codes, the
// micro-operation table and sign-magnitude helpers. No dependencies.
package rau_pkg;

  localparam int OperandWidth = 16;
  localparam int MagWidth     = 2 * OperandWidth;
  localparam int CmpWidth     = (MagWidth > 33) ? MagWidth : 33;
  localparam int CntWidth     = $clog2(MagWidth + 1);

  localparam logic [2:0] FuncAdd = 3'd0;
  localparam logic [2:0] FuncSub = 3'd1;
  localparam logic [2:0] FuncMul = 3'd2;
  localparam logic [2:0] FuncDiv = 3'd3;
  localparam logic [2:0] FuncNeg = 3'd4;
  localparam logic [2:0] FuncInc = 3'd5;
  localparam logic [2:0] FuncDec = 3'd6;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusZero = 2'd1;
  localparam logic [1:0] StatusOvf  = 2'd2;

  typedef struct packed {
    logic [2:0]                     func;
    logic signed [OperandWidth-1:0] a_num;
    logic signed [OperandWidth-1:0] a_den;
    logic signed [OperandWidth-1:0] b_num;
    logic signed [OperandWidth-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic [1:0]         status;
  } rau_out_t;

  typedef struct packed {
    logic                neg;
    logic [MagWidth-1:0] mag;
  } sm_t;

  typedef enum logic [2:0] {
    SEL_AN, SEL_AD, SEL_BN, SEL_BD, SEL_ONE
  } opnd_sel_e;

  typedef enum logic [2:0] {
    ACT_SETN, ACT_NEGN, ACT_ADDN, ACT_SUBN, ACT_SETD
  } mop_act_e;

  typedef struct packed {
    opnd_sel_e xsel;
    opnd_sel_e ysel;
    mop_act_e  act;
    logic      last;
  } mop_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD_IN, DP_W_FROM_A, DP_W_FROM_B, DP_A_FROM_W, DP_B_FROM_W,
    DP_E_INIT, DP_E_START, DP_E_STEP, DP_G_START, DP_QN, DP_QD,
    DP_MUL, DP_APPLY, DP_OUT_ZERO, DP_OUT_RES
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] mop_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_in;
    logic binary;
    logic reduce_res;
    logic rd_zero;
    logic div_done;
    logic y_zero;
    logic g_zero;
    logic mop_last;
  } dp_sts_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LOAD_B, S_R_INIT, S_R_TEST, S_R_EUC, S_R_G, S_R_QN,
    S_R_QD, S_R_END, S_MUL, S_APPLY, S_RES_CHK, S_FIN_ZERO, S_FIN_RES
  } ctrl_state_e;

  typedef enum logic [1:0] {
    PH_A, PH_B, PH_R
  } phase_e;

  typedef enum logic [1:0] {
    DIV_IDLE, DIV_ALIGN, DIV_SUB
  } div_state_e;

  function automatic sm_t sm_make(logic neg, logic [MagWidth-1:0] mag);
    sm_t r;
    r.mag = mag;
    r.neg = neg && (mag != '0);
    return r;
  endfunction

  function automatic sm_t sm_from_field(logic [OperandWidth-1:0] v);
    logic [OperandWidth-1:0] m;
    m = v[OperandWidth-1] ? (~v + 1'b1) : v;
    return sm_make(v[OperandWidth-1], MagWidth'(m));
  endfunction

  function automatic sm_t sm_add(sm_t x, sm_t y);
    sm_t r;
    if (x.neg == y.neg) begin
      r = sm_make(x.neg, x.mag + y.mag);
    end else if (x.mag >= y.mag) begin
      r = sm_make(x.neg, x.mag - y.mag);
    end else begin
      r = sm_make(y.neg, y.mag - x.mag);
    end
    return r;
  endfunction

  function automatic logic fits32(sm_t x);
    logic [CmpWidth-1:0] e;
    e = CmpWidth'(x.mag);
    return x.neg ? (e <= CmpWidth'(33'h080000000)) : (e <= CmpWidth'(33'h07FFFFFFF));
  endfunction

  function automatic logic [31:0] to32(sm_t x);
    logic [CmpWidth-1:0] e;
    e = CmpWidth'(x.mag);
    if (x.neg) begin
      e = ~e + 1'b1;
    end
    return e[31:0];
  endfunction

  function automatic mop_t mk_mop(opnd_sel_e x, opnd_sel_e y, mop_act_e a, logic l);
    mop_t m;
    m.xsel = x;
    m.ysel = y;
    m.act  = a;
    m.last = l;
    return m;
  endfunction

  // Product schedule per opcode: each step multiplies two operands and folds
  // the product into the working numerator or denominator.
  function automatic mop_t mop_lookup(logic [2:0] func, logic [1:0] idx);
    mop_t m;
    m = mk_mop(SEL_AD, SEL_ONE, ACT_SETD, 1'b1);
    case (func)
      FuncAdd, FuncSub: begin
        case (idx)
          2'd0:    m = mk_mop(SEL_AN, SEL_BD, ACT_SETN, 1'b0);
          2'd1:    m = mk_mop(SEL_BN, SEL_AD, (func == FuncAdd) ? ACT_ADDN : ACT_SUBN, 1'b0);
          default: m = mk_mop(SEL_AD, SEL_BD, ACT_SETD, 1'b1);
        endcase
      end
      FuncMul: begin
        case (idx)
          2'd0:    m = mk_mop(SEL_AN, SEL_BN, ACT_SETN, 1'b0);
          default: m = mk_mop(SEL_AD, SEL_BD, ACT_SETD, 1'b1);
        endcase
      end
      FuncDiv: begin
        case (idx)
          2'd0:    m = mk_mop(SEL_AN, SEL_BD, ACT_SETN, 1'b0);
          default: m = mk_mop(SEL_AD, SEL_BN, ACT_SETD, 1'b1);
        endcase
      end
      FuncNeg: begin
        case (idx)
          2'd0:    m = mk_mop(SEL_AN, SEL_ONE, ACT_NEGN, 1'b0);
          default: m = mk_mop(SEL_AD, SEL_ONE, ACT_SETD, 1'b1);
        endcase
      end
      FuncInc, FuncDec: begin
        case (idx)
          2'd0:    m = mk_mop(SEL_AN, SEL_ONE, ACT_SETN, 1'b0);
          2'd1:    m = mk_mop(SEL_AD, SEL_ONE, (func == FuncInc) ? ACT_ADDN : ACT_SUBN, 1'b0);
          default: m = mk_mop(SEL_AD, SEL_ONE, ACT_SETD, 1'b1);
        endcase
      end
      default: begin
        case (idx)
          2'd0:    m = mk_mop(SEL_AN, SEL_ONE, ACT_SETN, 1'b0);
          default: m = mk_mop(SEL_AD, SEL_ONE, ACT_SETD, 1'b1);
        endcase
      end
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/rau_div.sv =====
// Iterative unsigned divider: aligns the divisor, then one subtract per cycle.
// Depends on rau_pkg.
module rau_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rau_pkg::MagWidth-1:0] dividend_i,
  input  logic [rau_pkg::MagWidth-1:0] divisor_i,
  output logic                         done_o,
  output logic [rau_pkg::MagWidth-1:0] quot_o,
  output logic [rau_pkg::MagWidth-1:0] rem_o
);
  import rau_pkg::*;

  div_state_e          state_q, state_d;
  logic                done_q, done_d;
  logic [MagWidth-1:0] rem_q, rem_d;
  logic [MagWidth-1:0] quo_q, quo_d;
  logic [MagWidth:0]   dvs_q, dvs_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          rem_d = dividend_i;
          dvs_d = {1'b0, divisor_i};
          quo_d = '0;
          cnt_d = '0;
          if (divisor_i == '0) begin
            done_d = 1'b1;
          end else begin
            state_d = DIV_ALIGN;
          end
        end
      end
      DIV_ALIGN: begin
        if ({dvs_q[MagWidth-1:0], 1'b0} <= {1'b0, rem_q}) begin
          dvs_d = {dvs_q[MagWidth-1:0], 1'b0};
          cnt_d = cnt_q + 1'b1;
        end else begin
          state_d = DIV_SUB;
        end
      end
      DIV_SUB: begin
        if ({1'b0, rem_q} >= dvs_q) begin
          rem_d = rem_q - dvs_q[MagWidth-1:0];
          quo_d = {quo_q[MagWidth-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[MagWidth-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end else begin
          dvs_d = {1'b0, dvs_q[MagWidth:1]};
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/rau_dp.sv =====
// Datapath: operand and working registers, multiplier, Euclid registers and
// the result register. Depends on rau_pkg and rau_div.
module rau_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::dp_cmd_t  cmd_i,
  output rau_pkg::dp_sts_t  sts_o,
  input  rau_pkg::rau_in_t  in_data_i,
  output rau_pkg::rau_out_t out_data_o
);
  import rau_pkg::*;

  logic [2:0]          func_q, func_d;
  sm_t                 an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  sm_t                 wn_q, wn_d, wd_q, wd_d, prod_q, prod_d;
  logic [MagWidth-1:0] ex_q, ex_d, ey_q, ey_d;
  logic                par_q, par_d, gneg_q, gneg_d;
  rau_out_t            out_q, out_d;

  logic                div_start, div_done;
  logic [MagWidth-1:0] div_x, div_y, div_quot, div_rem;
  mop_t                mop;
  sm_t                 xs, ys;

  function automatic sm_t pick(opnd_sel_e s, sm_t an, sm_t ad, sm_t bn, sm_t bd);
    sm_t r;
    case (s)
      SEL_AN:  r = an;
      SEL_AD:  r = ad;
      SEL_BN:  r = bn;
      SEL_BD:  r = bd;
      default: r = sm_make(1'b0, MagWidth'(1));
    endcase
    return r;
  endfunction

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_x),
    .divisor_i  (div_y),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    an_q   <= an_d;
    ad_q   <= ad_d;
    bn_q   <= bn_d;
    bd_q   <= bd_d;
    wn_q   <= wn_d;
    wd_q   <= wd_d;
    prod_q <= prod_d;
    ex_q   <= ex_d;
    ey_q   <= ey_d;
    par_q  <= par_d;
    gneg_q <= gneg_d;
    out_q  <= out_d;
  end

  assign mop = mop_lookup(func_q, cmd_i.mop_idx);
  assign xs  = pick(mop.xsel, an_q, ad_q, bn_q, bd_q);
  assign ys  = pick(mop.ysel, an_q, ad_q, bn_q, bd_q);

  always_comb begin
    func_d    = func_q;
    an_d      = an_q;
    ad_d      = ad_q;
    bn_d      = bn_q;
    bd_d      = bd_q;
    wn_d      = wn_q;
    wd_d      = wd_q;
    prod_d    = prod_q;
    ex_d      = ex_q;
    ey_d      = ey_q;
    par_d     = par_q;
    gneg_d    = gneg_q;
    out_d     = out_q;
    div_start = 1'b0;
    div_x     = ex_q;
    div_y     = ey_q;
    case (cmd_i.op)
      DP_LOAD_IN: begin
        func_d = in_data_i.func;
        an_d   = sm_from_field(in_data_i.a_num);
        ad_d   = sm_from_field(in_data_i.a_den);
        bn_d   = sm_from_field(in_data_i.b_num);
        bd_d   = sm_from_field(in_data_i.b_den);
      end
      DP_W_FROM_A: begin
        wn_d = an_q;
        wd_d = ad_q;
      end
      DP_W_FROM_B: begin
        wn_d = bn_q;
        wd_d = bd_q;
      end
      DP_A_FROM_W: begin
        an_d = wn_q;
        ad_d = wd_q;
      end
      DP_B_FROM_W: begin
        bn_d = wn_q;
        bd_d = wd_q;
      end
      DP_E_INIT: begin
        ex_d  = wn_q.mag;
        ey_d  = wd_q.mag;
        par_d = 1'b0;
      end
      DP_E_START: div_start = 1'b1;
      DP_E_STEP: begin
        ex_d  = ey_q;
        ey_d  = div_rem;
        par_d = !par_q;
      end
      DP_G_START: begin
        // An odd step count leaves the gcd with the denominator's sign.
        gneg_d    = par_q ? wd_q.neg : wn_q.neg;
        div_start = 1'b1;
        div_x     = wn_q.mag;
        div_y     = ex_q;
      end
      DP_QN: begin
        wn_d      = sm_make(wn_q.neg ^ gneg_q, div_quot);
        div_start = 1'b1;
        div_x     = wd_q.mag;
        div_y     = ex_q;
      end
      DP_QD: wd_d = sm_make(wd_q.neg ^ gneg_q, div_quot);
      DP_MUL: begin
        prod_d = sm_make(xs.neg ^ ys.neg,
                         MagWidth'(xs.mag[OperandWidth-1:0]) *
                         MagWidth'(ys.mag[OperandWidth-1:0]));
      end
      DP_APPLY: begin
        case (mop.act)
          ACT_SETN: wn_d = prod_q;
          ACT_NEGN: wn_d = sm_make(!prod_q.neg, prod_q.mag);
          ACT_ADDN: wn_d = sm_add(wn_q, prod_q);
          ACT_SUBN: wn_d = sm_add(wn_q, sm_make(!prod_q.neg, prod_q.mag));
          default:  wd_d = prod_q;
        endcase
      end
      DP_OUT_ZERO: begin
        out_d.res_num = '0;
        out_d.res_den = '0;
        out_d.status  = StatusZero;
      end
      DP_OUT_RES: begin
        if (fits32(wn_q) && fits32(wd_q)) begin
          out_d.res_num = to32(wn_q);
          out_d.res_den = to32(wd_q);
          out_d.status  = StatusOk;
        end else begin
          out_d.res_num = '0;
          out_d.res_den = '0;
          out_d.status  = StatusOvf;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.binary     = (func_q <= FuncDiv);
    sts_o.zero_in    = (ad_q.mag == '0) || ((func_q <= FuncDiv) && (bd_q.mag == '0));
    sts_o.reduce_res = (func_q <= FuncDec);
    sts_o.rd_zero    = (wd_q.mag == '0);
    sts_o.div_done   = div_done;
    sts_o.y_zero     = (ey_q == '0);
    sts_o.g_zero     = (ex_q == '0);
    sts_o.mop_last   = mop.last;
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/rau_ctrl.sv =====
// Controller: sequences operand reduction, products, result reduction and
// the output handshake. Depends on rau_pkg.
module rau_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rau_pkg::dp_cmd_t cmd_o,
  input  rau_pkg::dp_sts_t sts_i
);
  import rau_pkg::*;

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_A;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    idx_d         = idx_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.op      = DP_NOP;
    cmd_o.mop_idx = idx_q;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD_IN;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.zero_in) begin
          state_d = S_FIN_ZERO;
        end else begin
          cmd_o.op = DP_W_FROM_A;
          phase_d  = PH_A;
          state_d  = S_R_INIT;
        end
      end
      S_LOAD_B: begin
        cmd_o.op = DP_W_FROM_B;
        phase_d  = PH_B;
        state_d  = S_R_INIT;
      end
      S_R_INIT: begin
        cmd_o.op = DP_E_INIT;
        state_d  = S_R_TEST;
      end
      S_R_TEST: begin
        if (sts_i.y_zero) begin
          state_d = S_R_G;
        end else begin
          cmd_o.op = DP_E_START;
          state_d  = S_R_EUC;
        end
      end
      S_R_EUC: begin
        if (sts_i.div_done) begin
          cmd_o.op = DP_E_STEP;
          state_d  = S_R_TEST;
        end
      end
      S_R_G: begin
        if (sts_i.g_zero) begin
          state_d = S_R_END;
        end else begin
          cmd_o.op = DP_G_START;
          state_d  = S_R_QN;
        end
      end
      S_R_QN: begin
        if (sts_i.div_done) begin
          cmd_o.op = DP_QN;
          state_d  = S_R_QD;
        end
      end
      S_R_QD: begin
        if (sts_i.div_done) begin
          cmd_o.op = DP_QD;
          state_d  = S_R_END;
        end
      end
      S_R_END: begin
        idx_d = '0;
        case (phase_q)
          PH_A: begin
            cmd_o.op = DP_A_FROM_W;
            state_d  = sts_i.binary ? S_LOAD_B : S_MUL;
          end
          PH_B: begin
            cmd_o.op = DP_B_FROM_W;
            state_d  = S_MUL;
          end
          default: state_d = S_FIN_RES;
        endcase
      end
      S_MUL: begin
        cmd_o.op = DP_MUL;
        state_d  = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.op = DP_APPLY;
        if (sts_i.mop_last) begin
          state_d = S_RES_CHK;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_RES_CHK: begin
        if (sts_i.rd_zero) begin
          state_d = S_FIN_ZERO;
        end else if (sts_i.reduce_res) begin
          phase_d = PH_R;
          state_d = S_R_INIT;
        end else begin
          state_d = S_FIN_RES;
        end
      end
      S_FIN_ZERO, S_FIN_RES: begin
        // The result register is written only once its previous content moves.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = (state_q == S_FIN_ZERO) ? DP_OUT_ZERO : DP_OUT_RES;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_R_EUC || state_q == S_R_QN || state_q == S_R_QD))
    else $error("divider finished outside a wait state");

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CHECK))
    else $error("input transfer did not start a new item");

  a_fin_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN_ZERO || state_q == S_FIN_RES) && !out_valid_q)
      |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not presented");
`endif

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl, rau_dp.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_ready_o   in_data_i  (rau_in_t)
//   output   out        out_valid_o / out_ready_i out_data_o (rau_out_t)
//
// One item at a time. An item with a zero operand denominator skips the divider;
// otherwise the time an item takes is set by the iterative divider, which
// runs every Euclid remainder step and the two quotient divisions of each of
// up to three reductions (one subtract or alignment shift per cycle).
// Reset clears the controller and divider state.
// A new item is taken while a finished result still waits on the output;
// a stalled output only holds the next item at its final write.
module rational_arithmetic_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rau_pkg::rau_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rau_pkg::rau_out_t out_data_o
);
  import rau_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rau_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for rational_arithmetic_unit: drives fraction operations
// and compares every result with a behavioral fraction calculator.
// Depends on rau_pkg and the RTL of rational_arithmetic_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  typedef struct {
    logic        neg;
    logic [63:0] mag;
  } frac_part_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  rau_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rau_out_t out_data_o;

  rau_in_t  pending_ops[$];
  rau_out_t expected_results[$];
  int unsigned error_count = 0;
  bit stimulus_done = 1'b0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  bit hold_sender = 1'b0;

  always #5 clk_i = ~clk_i;

  rational_arithmetic_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  function automatic frac_part_t mk_part(logic neg, logic [63:0] mag);
    frac_part_t p;
    p.mag = mag;
    p.neg = neg && (mag != 0);
    return p;
  endfunction

  function automatic frac_part_t from_field(logic [15:0] v);
    return mk_part(v[15], v[15] ? 64'(16'(-v)) : 64'(v));
  endfunction

  function automatic frac_part_t part_mul(frac_part_t x, frac_part_t y);
    return mk_part(x.neg != y.neg, x.mag * y.mag);
  endfunction

  function automatic frac_part_t part_add(frac_part_t x, frac_part_t y);
    if (x.neg == y.neg) return mk_part(x.neg, x.mag + y.mag);
    if (x.mag >= y.mag) return mk_part(x.neg, x.mag - y.mag);
    return mk_part(y.neg, y.mag - x.mag);
  endfunction

  // Truncating Euclid: the gcd sign depends on the parity of the step count.
  function automatic void reduce_frac(inout frac_part_t n, inout frac_part_t d);
    logic [63:0] x, y, r;
    int unsigned steps;
    logic gneg;
    x = n.mag;
    y = d.mag;
    steps = 0;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
      steps++;
    end
    gneg = steps[0] ? d.neg : n.neg;
    if (x != 0) begin
      n = mk_part(n.neg != gneg, n.mag / x);
      d = mk_part(d.neg != gneg, d.mag / x);
    end
  endfunction

  function automatic logic fits_word(frac_part_t x);
    return x.neg ? (x.mag <= 64'h8000_0000) : (x.mag <= 64'h7FFF_FFFF);
  endfunction

  function automatic rau_out_t compute_fraction(rau_in_t op);
    rau_out_t res;
    frac_part_t an, ad, bn, bd, rn, rd;
    logic binary;
    res = '{res_num: '0, res_den: '0, status: StatusZero};
    an = from_field(op.a_num);
    ad = from_field(op.a_den);
    bn = from_field(op.b_num);
    bd = from_field(op.b_den);
    binary = op.func <= FuncDiv;
    if (ad.mag == 0 || (binary && bd.mag == 0)) return res;
    reduce_frac(an, ad);
    if (binary) reduce_frac(bn, bd);
    rd = part_mul(ad, bd);
    case (op.func)
      FuncAdd: rn = part_add(part_mul(an, bd), part_mul(bn, ad));
      FuncSub: rn = part_add(part_mul(an, bd), mk_part(!part_mul(bn, ad).neg,
                                                       part_mul(bn, ad).mag));
      FuncMul: rn = part_mul(an, bn);
      FuncDiv: begin
        rn = part_mul(an, bd);
        rd = part_mul(ad, bn);
      end
      FuncNeg: begin
        rn = mk_part(!an.neg, an.mag);
        rd = ad;
      end
      FuncInc: begin
        rn = part_add(an, ad);
        rd = ad;
      end
      FuncDec: begin
        rn = part_add(an, mk_part(!ad.neg, ad.mag));
        rd = ad;
      end
      default: begin
        rn = an;
        rd = ad;
      end
    endcase
    if (rd.mag == 0) return res;
    if (op.func <= FuncDec) reduce_frac(rn, rd);
    if (!fits_word(rn) || !fits_word(rd)) begin
      res.status = StatusOvf;
      return res;
    end
    res.res_num = rn.neg ? 32'(-rn.mag) : 32'(rn.mag);
    res.res_den = rd.neg ? 32'(-rd.mag) : 32'(rd.mag);
    res.status = StatusOk;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'($signed($urandom_range(0, 16)) - 8);
      1: return 16'($urandom_range(0, 255));
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_op(logic [2:0] f, logic [15:0] an, logic [15:0] ad,
                         logic [15:0] bn, logic [15:0] bd);
    rau_in_t op;
    op.func = f;
    op.a_num = an;
    op.a_den = ad;
    op.b_num = bn;
    op.b_den = bd;
    pending_ops.push_back(op);
  endtask

  // Driver: valid is lowered only in the step after a transfer, before any wait.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_results.push_back(compute_fraction(in_data_i));
      send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
      in_valid_i <= 1'b0;
    end else if (rst_ni && !in_valid_i && !hold_sender && pending_ops.size() > 0) begin
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
      end else begin
        in_data_i <= pending_ops.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // Monitor and output stall.
  always @(posedge clk_i) begin
    rau_out_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_data_o.res_num, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.res_num !== want.res_num)
          report_mismatch("res_num", out_data_o.res_num, want.res_num);
        if (out_data_o.res_den !== want.res_den)
          report_mismatch("res_den", out_data_o.res_den, want.res_den);
        if (out_data_o.status !== want.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
      end
      recv_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
      out_ready_i <= 1'b0;
    end else if (rst_ni) begin
      if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    logic [2:0] f;
    // Directed cases: field extremes, every opcode, zero denominators,
    // a division by zero, results near the 32-bit limit and a negative gcd.
    push_op(FuncAdd, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    push_op(FuncAdd, 16'h7FFF, 16'h0001, 16'h7FFF, 16'h0001);
    push_op(FuncSub, 16'h8000, 16'h0001, 16'h7FFF, 16'h0001);
    push_op(FuncMul, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
    push_op(FuncMul, 16'h8000, 16'h7FFF, 16'h7FFD, 16'h7FFE);
    push_op(FuncAdd, 16'h7FFF, 16'h7FFE, 16'h7FFD, 16'h7FFC);
    push_op(FuncDiv, 16'd3, 16'd4, 16'd0, 16'd5);
    push_op(FuncDiv, 16'hFFFE, 16'd6, 16'hFFFD, 16'hFFF7);
    push_op(FuncNeg, 16'd4, 16'hFFFA, 16'd0, 16'd0);
    push_op(FuncInc, 16'hFFFF, 16'd2, 16'hFFFF, 16'hFFFF);
    push_op(FuncDec, 16'd0, 16'h8000, 16'd1, 16'd0);
    push_op(FuncAdd, 16'd1, 16'd0, 16'd1, 16'd1);
    push_op(FuncSub, 16'd1, 16'd2, 16'd1, 16'd0);
    push_op(FuncNeg, 16'd5, 16'd0, 16'd1, 16'd1);
    push_op(FuncSub, 16'd1, 16'd2, 16'd1, 16'd2);
    push_op(FuncAdd, 16'hFFF4, 16'd8, 16'd6, 16'hFFF8);
    push_op(3'd7, 16'd6, 16'hFFF7, 16'd0, 16'd0);
    push_op(3'd7, 16'd6, 16'd0, 16'd0, 16'd0);
    push_op(FuncMul, 16'd0, 16'hFFFF, 16'd0, 16'h7FFF);
    for (int i = 0; i < 950; i++) begin
      f = $urandom_range(0, 15) == 0 ? 3'd7 : 3'($urandom_range(0, 6));
      push_op(f, rand_value(), rand_value(), rand_value(), rand_value());
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Hold the sender once until all results are drained.
    wait (pending_ops.size() < 500);
    @(negedge clk_i);
    hold_sender = 1'b1;
    do @(negedge clk_i); while (in_valid_i || expected_results.size() != 0);
    hold_sender = 1'b0;
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (500) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
